>>> design/fmt_pkg.sv
// ----------------------------------------------------------------------------
// fmt_pkg: shared types and constants of the flow metering table
// Table geometry, protocol constants, the flow key and the stored entry.
// ----------------------------------------------------------------------------
package fmt_pkg;

  localparam int unsigned TABLE_ENTRIES = 1024;
  localparam int unsigned IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int unsigned CNT_W         = $clog2(TABLE_ENTRIES + 1);

  localparam logic [39:0] INTERVAL_RESET = 40'd60000000000;
  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_TCP      = 8'd6;
  localparam logic [7:0]  PROTO_UDP      = 8'd17;
  localparam logic [15:0] MIN_FRAME_LEN  = 16'd34;
  // Ethernet header plus both port words
  localparam logic [16:0] PORT_ROOM_BASE = 17'd18;

  typedef struct packed {
    logic [31:0] src_address;
    logic [31:0] dst_address;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [7:0]  protocol;
  } flow_key_t;

  typedef struct packed {
    flow_key_t   key;
    logic [63:0] packets;
    logic [63:0] bytes;
    logic [63:0] start_ns;
  } entry_t;

endpackage

>>> design/fmt_parse.sv
// ----------------------------------------------------------------------------
// fmt_parse: header check and flow key normalisation
// Decides whether a request is a countable TCP/UDP over IPv4 packet and
// builds its five-tuple key, swapped for the ingress direction.
// ----------------------------------------------------------------------------
module fmt_parse (
  input  logic [15:0]        frame_length_i,
  input  logic [15:0]        ether_type_i,
  input  logic [7:0]         ip_protocol_i,
  input  logic [3:0]         header_words_i,
  input  logic [31:0]        src_address_i,
  input  logic [31:0]        dst_address_i,
  input  logic [15:0]        sport_i,
  input  logic [15:0]        dport_i,
  input  logic               is_ingress_i,
  output logic               ok_o,
  output fmt_pkg::flow_key_t key_o
);
  import fmt_pkg::*;

  logic [16:0] need_len;

  // Room for both port words after the IP header
  assign need_len = PORT_ROOM_BASE + {11'd0, header_words_i, 2'b00};

  assign ok_o = (frame_length_i >= MIN_FRAME_LEN) &&
                (ether_type_i == ETHERTYPE_IPV4) &&
                ((ip_protocol_i == PROTO_TCP) || (ip_protocol_i == PROTO_UDP)) &&
                (need_len <= {1'b0, frame_length_i});

  // Swap source and destination for ingress
  always_comb begin
    key_o.protocol = ip_protocol_i;
    if (is_ingress_i) begin
      key_o.src_address = dst_address_i;
      key_o.dst_address = src_address_i;
      key_o.sport       = dport_i;
      key_o.dport       = sport_i;
    end else begin
      key_o.src_address = src_address_i;
      key_o.dst_address = dst_address_i;
      key_o.sport       = sport_i;
      key_o.dport       = dport_i;
    end
  end

endmodule

>>> design/flow_metering_table.sv
// ----------------------------------------------------------------------------
// flow_metering_table: IPv4 five-tuple flow meter
// Counts packets and bytes per flow and exports a record when a flow ages.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one parsed packet header
//   per request. Packets that are not TCP/UDP over IPv4 with room for the
//   port words are taken and dropped without leaving idle.
//   Flows are held in a single-port table memory with registered reads,
//   filled in order; a fill count marks the live entries. Each packet
//   scans the live entries one per cycle, then updates one entry or, while
//   there is room, appends one. The linear scan sets how long a packet takes,
//   which grows with the number of flows held.
//   Export records leave through an output register (out_valid_o /
//   out_stall_i) in the cycle after the update; a new packet is taken while a
//   record still waits. If an update wants to export while the register is
//   still full and stalled, the block holds until it is taken.
//   Reset empties the table at once (fill count to zero), export interval 60 s.
//   The user writes the interval with cfg_we_i only while idle; not enforced.
// ----------------------------------------------------------------------------
module flow_metering_table (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [39:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] frame_length_i,
  input  logic [15:0] ether_type_i,
  input  logic [7:0]  ip_protocol_i,
  input  logic [3:0]  header_words_i,
  input  logic [15:0] total_length_i,
  input  logic [31:0] src_address_i,
  input  logic [31:0] dst_address_i,
  input  logic [15:0] sport_i,
  input  logic [15:0] dport_i,
  input  logic        is_ingress_i,
  input  logic [63:0] timestamp_ns_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] exp_src_address_o,
  output logic [31:0] exp_dst_address_o,
  output logic [15:0] exp_sport_o,
  output logic [15:0] exp_dport_o,
  output logic [7:0]  exp_protocol_o,
  output logic [63:0] exp_packets_o,
  output logic [63:0] exp_bytes_o,
  output logic [63:0] exp_start_ns_o,
  output logic [63:0] exp_end_ns_o
);
  import fmt_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_UPDATE = 4'b0100,
    S_INSERT = 4'b1000
  } state_e;

  state_e      state_q, state_d;
  logic [39:0] interval_q;
  logic [CNT_W-1:0] fill_q, fill_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic [IDX_W-1:0] cmp_idx_q;
  logic        rvalid_q;
  entry_t      rdata_q;
  entry_t      mem_q [TABLE_ENTRIES];

  flow_key_t   key_q, pkt_key;
  logic [15:0] tlen_q;
  logic [63:0] now_q;
  logic        pkt_ok, accept, match, rd_en, wr_en;
  logic [IDX_W-1:0] wr_idx;
  entry_t      wr_data;
  logic [63:0] new_packets, new_bytes, age;
  logic        expire, out_free, load_out;
  logic        out_valid_q;
  entry_t      out_q;
  logic [63:0] out_end_q;

  fmt_parse u_parse (
    .frame_length_i (frame_length_i),
    .ether_type_i   (ether_type_i),
    .ip_protocol_i  (ip_protocol_i),
    .header_words_i (header_words_i),
    .src_address_i  (src_address_i),
    .dst_address_i  (dst_address_i),
    .sport_i        (sport_i),
    .dport_i        (dport_i),
    .is_ingress_i   (is_ingress_i),
    .ok_o           (pkt_ok),
    .key_o          (pkt_key)
  );

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  // Compare the entry read last cycle against the packet key
  assign match = (state_q == S_SCAN) && rvalid_q && (rdata_q.key == key_q);
  assign rd_en = (state_q == S_SCAN) && !match && (idx_q < fill_q);

  // Counter update and age test on the hit entry
  assign new_packets = rdata_q.packets + 64'd1;
  assign new_bytes   = rdata_q.bytes + {48'd0, tlen_q};
  assign age         = now_q - rdata_q.start_ns;
  assign expire      = (age > {24'd0, interval_q});
  assign out_free    = !out_valid_q || !out_stall_i;
  assign load_out    = (state_q == S_UPDATE) && expire && out_free;

  // Sequence the scan, update and append
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    fill_d  = fill_q;
    wr_en   = 1'b0;
    wr_idx  = cmp_idx_q;
    wr_data = rdata_q;
    unique case (state_q)
      S_IDLE: begin
        idx_d = '0;
        if (accept && pkt_ok) begin
          state_d = (fill_q == '0) ? S_INSERT : S_SCAN;
        end
      end
      S_SCAN: begin
        if (match) begin
          state_d = S_UPDATE;
        end else if (rd_en) begin
          idx_d = idx_q + CNT_W'(1);
        end else begin
          state_d = S_INSERT;
        end
      end
      S_UPDATE: begin
        wr_idx = cmp_idx_q;
        if (!expire) begin
          wr_en           = 1'b1;
          wr_data.packets = new_packets;
          wr_data.bytes   = new_bytes;
          state_d         = S_IDLE;
        end else if (out_free) begin
          wr_en            = 1'b1;
          wr_data.packets  = '0;
          wr_data.bytes    = '0;
          wr_data.start_ns = now_q;
          state_d          = S_IDLE;
        end
      end
      S_INSERT: begin
        wr_idx           = fill_q[IDX_W-1:0];
        wr_data.key      = key_q;
        wr_data.packets  = 64'd1;
        wr_data.bytes    = {48'd0, tlen_q};
        wr_data.start_ns = now_q;
        if (fill_q < CNT_W'(TABLE_ENTRIES)) begin
          wr_en  = 1'b1;
          fill_d = fill_q + CNT_W'(1);
        end
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= '0;
      idx_q       <= '0;
      rvalid_q    <= 1'b0;
      out_valid_q <= 1'b0;
      interval_q  <= INTERVAL_RESET;
    end else begin
      state_q  <= state_d;
      fill_q   <= fill_d;
      idx_q    <= idx_d;
      rvalid_q <= rd_en;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        interval_q <= cfg_wdata_i;
      end
    end
  end

  // Capture the request and the export record
  always_ff @(posedge clk_i) begin
    if (accept) begin
      key_q  <= pkt_key;
      tlen_q <= total_length_i;
      now_q  <= timestamp_ns_i;
    end
    if (rd_en) begin
      cmp_idx_q <= idx_q[IDX_W-1:0];
    end
    if (load_out) begin
      out_q.key      <= key_q;
      out_q.packets  <= new_packets;
      out_q.bytes    <= new_bytes;
      out_q.start_ns <= rdata_q.start_ns;
      out_end_q      <= now_q;
    end
  end

  // Table memory: one registered read, one write
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= mem_q[idx_q[IDX_W-1:0]];
    end
    if (wr_en) begin
      mem_q[wr_idx] <= wr_data;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign exp_src_address_o = out_q.key.src_address;
  assign exp_dst_address_o = out_q.key.dst_address;
  assign exp_sport_o       = out_q.key.sport;
  assign exp_dport_o       = out_q.key.dport;
  assign exp_protocol_o    = out_q.key.protocol;
  assign exp_packets_o     = out_q.packets;
  assign exp_bytes_o       = out_q.bytes;
  assign exp_start_ns_o    = out_q.start_ns;
  assign exp_end_ns_o      = out_end_q;

`ifndef NO_ASSERTIONS
  a_onehot_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("state register lost its one-hot code");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CNT_W'(TABLE_ENTRIES))
    else $error("fill count beyond table size");

  a_fill_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q != $past(fill_q)) |-> (fill_q == $past(fill_q) + CNT_W'(1)))
    else $error("fill count moved by other than one");

  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(rd_en && wr_en))
    else $error("table read and write in the same cycle");
`endif

endmodule

>>> bench/flow_meter_checker.sv
// ----------------------------------------------------------------------------
// flow_meter_checker: record predictor and scoreboard for the flow meter
// Watches the interval register, the packet channel and the export channel,
// keeps its own flow table, and compares every export record field by field
// with the oldest predicted record.
// ----------------------------------------------------------------------------
module flow_meter_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [39:0] cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_stall_o,
  input  logic [15:0] frame_length_i,
  input  logic [15:0] ether_type_i,
  input  logic [7:0]  ip_protocol_i,
  input  logic [3:0]  header_words_i,
  input  logic [15:0] total_length_i,
  input  logic [31:0] src_address_i,
  input  logic [31:0] dst_address_i,
  input  logic [15:0] sport_i,
  input  logic [15:0] dport_i,
  input  logic        is_ingress_i,
  input  logic [63:0] timestamp_ns_i,
  input  logic        out_valid_o,
  input  logic        out_stall_i,
  input  logic [31:0] exp_src_address_o,
  input  logic [31:0] exp_dst_address_o,
  input  logic [15:0] exp_sport_o,
  input  logic [15:0] exp_dport_o,
  input  logic [7:0]  exp_protocol_o,
  input  logic [63:0] exp_packets_o,
  input  logic [63:0] exp_bytes_o,
  input  logic [63:0] exp_start_ns_o,
  input  logic [63:0] exp_end_ns_o,
  output int          fail_cnt,
  output int          records_pending
);
  import fmt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    flow_key_t   key;
    logic [63:0] packets;
    logic [63:0] bytes;
    logic [63:0] start_ns;
    logic [63:0] end_ns;
  } record_t;

  entry_t      flows[TABLE_ENTRIES];
  int unsigned flows_held;
  logic [39:0] interval_ns;
  record_t     records_due[$];

  // Meter one packet header; queue a record when its flow ages out
  function automatic void meter_packet();
    flow_key_t   key;
    record_t     rec;
    int          hit;
    logic [16:0] room;
    hit  = -1;
    room = PORT_ROOM_BASE + {11'd0, header_words_i, 2'b00};
    if (frame_length_i < MIN_FRAME_LEN || ether_type_i != ETHERTYPE_IPV4) return;
    if (ip_protocol_i != PROTO_TCP && ip_protocol_i != PROTO_UDP) return;
    if (room > {1'b0, frame_length_i}) return;
    key.protocol = ip_protocol_i;
    if (is_ingress_i) begin
      key.src_address = dst_address_i;
      key.dst_address = src_address_i;
      key.sport       = dport_i;
      key.dport       = sport_i;
    end else begin
      key.src_address = src_address_i;
      key.dst_address = dst_address_i;
      key.sport       = sport_i;
      key.dport       = dport_i;
    end
    for (int i = 0; i < flows_held; i++) begin
      if (flows[i].key == key) begin
        hit = i;
        break;
      end
    end
    // New flow: append while there is room, drop otherwise
    if (hit < 0) begin
      if (flows_held < TABLE_ENTRIES) begin
        flows[flows_held] = '{key: key, packets: 64'd1,
                              bytes: {48'd0, total_length_i}, start_ns: timestamp_ns_i};
        flows_held++;
      end
      return;
    end
    flows[hit].packets += 64'd1;
    flows[hit].bytes   += {48'd0, total_length_i};
    if (timestamp_ns_i - flows[hit].start_ns > {24'd0, interval_ns}) begin
      rec = '{key: key, packets: flows[hit].packets, bytes: flows[hit].bytes,
              start_ns: flows[hit].start_ns, end_ns: timestamp_ns_i};
      records_due.push_back(rec);
      flows[hit].packets  = '0;
      flows[hit].bytes    = '0;
      flows[hit].start_ns = timestamp_ns_i;
    end
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      fail_cnt++;
      $display("%0t: %s mismatch: expected %h, actual %h", $realtime, name, want, got);
    end
  endfunction

  // Follow the register, the packet requests and the export requests
  always @(posedge clk_i or negedge rst_ni) begin
    record_t rec;
    if (!rst_ni) begin
      flows_held  = 0;
      interval_ns = INTERVAL_RESET;
      records_due.delete();
      fail_cnt    = 0;
    end else begin
      if (cfg_we_i) interval_ns = cfg_wdata_i;
      if (in_valid_i && !in_stall_o) meter_packet();
      if (out_valid_o && !out_stall_i) begin
        if (records_due.size() == 0) begin
          fail_cnt++;
          $display("%0t: export record with none expected: src %h dst %h packets %h",
                   $realtime, exp_src_address_o, exp_dst_address_o, exp_packets_o);
        end else begin
          rec = records_due.pop_front();
          check_field("src_address", 64'(rec.key.src_address), 64'(exp_src_address_o));
          check_field("dst_address", 64'(rec.key.dst_address), 64'(exp_dst_address_o));
          check_field("sport", 64'(rec.key.sport), 64'(exp_sport_o));
          check_field("dport", 64'(rec.key.dport), 64'(exp_dport_o));
          check_field("protocol", 64'(rec.key.protocol), 64'(exp_protocol_o));
          check_field("packets", rec.packets, exp_packets_o);
          check_field("bytes", rec.bytes, exp_bytes_o);
          check_field("start_ns", rec.start_ns, exp_start_ns_o);
          check_field("end_ns", rec.end_ns, exp_end_ns_o);
        end
      end
    end
    records_pending = records_due.size();
  end

endmodule

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for the flow metering table
// Drives directed and random packet headers through several export intervals
// with random idling on both channels in most phases, then fills the table to overflow.
// ----------------------------------------------------------------------------
module tb;
  import fmt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DRAIN_CYCLES   = 1100;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int POOL_FLOWS     = 20;
  localparam int PHASE_ITEMS    = 100;

  typedef struct {
    logic [15:0] flen;
    logic [15:0] etype;
    logic [7:0]  proto;
    logic [3:0]  hw;
    logic [15:0] tlen;
    logic [31:0] sa;
    logic [31:0] da;
    logic [15:0] sp;
    logic [15:0] dp;
    logic        ingress;
    logic [63:0] ts;
  } header_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we = 1'b0;
  logic [39:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  header_t     hdr = '{default: '0};
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] exp_src_address, exp_dst_address;
  logic [15:0] exp_sport, exp_dport;
  logic [7:0]  exp_protocol;
  logic [63:0] exp_packets, exp_bytes, exp_start_ns, exp_end_ns;
  int          fail_cnt, records_pending;

  int          send_gap_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_cycles = 0;
  int          quiet_cycles = 0;
  logic [63:0] now_ns = '0;
  header_t     pool[POOL_FLOWS];

  flow_metering_table dut (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .frame_length_i(hdr.flen), .ether_type_i(hdr.etype), .ip_protocol_i(hdr.proto),
    .header_words_i(hdr.hw), .total_length_i(hdr.tlen),
    .src_address_i(hdr.sa), .dst_address_i(hdr.da),
    .sport_i(hdr.sp), .dport_i(hdr.dp),
    .is_ingress_i(hdr.ingress), .timestamp_ns_i(hdr.ts),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .exp_src_address_o(exp_src_address), .exp_dst_address_o(exp_dst_address),
    .exp_sport_o(exp_sport), .exp_dport_o(exp_dport),
    .exp_protocol_o(exp_protocol), .exp_packets_o(exp_packets),
    .exp_bytes_o(exp_bytes), .exp_start_ns_o(exp_start_ns), .exp_end_ns_o(exp_end_ns)
  );

  flow_meter_checker checker_i (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .frame_length_i(hdr.flen), .ether_type_i(hdr.etype), .ip_protocol_i(hdr.proto),
    .header_words_i(hdr.hw), .total_length_i(hdr.tlen),
    .src_address_i(hdr.sa), .dst_address_i(hdr.da),
    .sport_i(hdr.sp), .dport_i(hdr.dp),
    .is_ingress_i(hdr.ingress), .timestamp_ns_i(hdr.ts),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .exp_src_address_o(exp_src_address), .exp_dst_address_o(exp_dst_address),
    .exp_sport_o(exp_sport), .exp_dport_o(exp_dport),
    .exp_protocol_o(exp_protocol), .exp_packets_o(exp_packets),
    .exp_bytes_o(exp_bytes), .exp_start_ns_o(exp_start_ns), .exp_end_ns_o(exp_end_ns),
    .fail_cnt, .records_pending
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Stall exports at random, or hold them off for a long stretch on request
  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      out_stall   <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // End the run when no request moves for too long
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_ni) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one header, with a random gap first, and hold it until taken
  task automatic offer(header_t h);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    hdr      <= h;
    do @(posedge clk_i); while (in_stall);
  endtask

  // Well-formed header with a random frame size that leaves room for the ports
  function automatic header_t well_formed(header_t key, logic ingress, logic [63:0] ts);
    header_t     h;
    int unsigned least;
    h       = key;
    h.etype = ETHERTYPE_IPV4;
    least   = 18 + 4 * h.hw;
    if (least < 34) least = 34;
    case ($urandom_range(0, 9))
      0:       h.flen = 16'(least);
      1:       h.flen = 16'hFFFF;
      default: h.flen = 16'($urandom_range(least, 1600));
    endcase
    h.tlen    = ($urandom_range(0, 15) == 0) ? 16'hFFFF : 16'($urandom_range(0, 1500));
    h.ingress = ingress;
    h.ts      = ts;
    return h;
  endfunction

  function automatic header_t random_key();
    header_t h;
    h       = '{default: '0};
    h.sa    = $urandom;
    h.da    = $urandom;
    h.sp    = 16'($urandom);
    h.dp    = 16'($urandom);
    h.proto = $urandom_range(0, 1) ? PROTO_TCP : PROTO_UDP;
    h.hw    = 4'($urandom_range(0, 15));
    return h;
  endfunction

  // Move the clock of the packet stream: mostly small steps, some jumps
  function automatic logic [63:0] advance_clock();
    case ($urandom_range(0, 19))
      0:       now_ns = now_ns - 64'($urandom_range(1, 100000));
      1:       now_ns = now_ns + 64'd70000000000;
      2:       now_ns = now_ns + 64'h0000_0200_0000_0000;
      3:       now_ns = {$urandom, $urandom};
      default: now_ns = now_ns + 64'($urandom_range(0, 3000));
    endcase
    return now_ns;
  endfunction

  // Write the interval once the last packet is done and all records are out
  task automatic set_interval(logic [39:0] value);
    in_valid <= 1'b0;
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    while (records_pending != 0) @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  initial begin
    header_t     h;
    header_t     k;
    logic [39:0] intervals[6];
    int          pick;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: filter edges, both directions, extreme fields and timestamps
    k = '{default: '0};
    k.sa = 32'hFFFF_FFFF; k.da = 32'h0; k.sp = 16'hFFFF; k.dp = 16'h0;
    k.proto = PROTO_TCP; k.hw = 4'd5;
    h = well_formed(k, 1'b0, 64'd0); h.flen = 16'd33; offer(h);
    h = well_formed(k, 1'b0, 64'd0); h.etype = 16'h86DD; offer(h);
    h = well_formed(k, 1'b0, 64'd0); h.proto = 8'd1; offer(h);
    h = well_formed(k, 1'b0, 64'd0); h.proto = 8'hFF; offer(h);
    h = well_formed(k, 1'b0, 64'd0); h.hw = 4'd15; h.flen = 16'd77; offer(h);
    h = well_formed(k, 1'b0, 64'd0); h.flen = 16'd34; h.tlen = 16'hFFFF; offer(h);
    h = well_formed(k, 1'b1, 64'd5); offer(h);
    h = well_formed(k, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF); h.tlen = 16'd0; offer(h);
    h = well_formed(k, 1'b1, 64'd10); offer(h);
    h = well_formed(k, 1'b0, 64'd60000000010); offer(h);
    h = well_formed(k, 1'b0, 64'd60000000011); offer(h);
    k.proto = PROTO_UDP; k.hw = 4'd15; k.sa = 32'h0; k.da = 32'hFFFF_FFFF;
    k.sp = 16'h0; k.dp = 16'hFFFF;
    h = well_formed(k, 1'b0, 64'd100); h.flen = 16'd78; offer(h);
    k.hw = 4'd0;
    h = well_formed(k, 1'b1, 64'd200); h.flen = 16'd34; offer(h);
    h = well_formed(k, 1'b1, 64'd50); offer(h);

    for (int i = 0; i < POOL_FLOWS; i++) pool[i] = random_key();
    intervals[0] = 40'd0;
    intervals[1] = 40'hFF_FFFF_FFFF;
    intervals[2] = 40'($urandom_range(1, 5000));
    intervals[3] = INTERVAL_RESET;
    intervals[4] = 40'd1000;
    intervals[5] = {8'd0, $urandom};

    // Random phases, one interval each, cycling through the idling patterns
    for (int phase = 0; phase < 6; phase++) begin
      set_interval(intervals[phase]);
      case (phase % 3)
        0:       begin send_gap_pct = 37; recv_stall_pct = 56; end
        1:       begin send_gap_pct = 56; recv_stall_pct = 37; end
        default: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
      endcase
      if (phase == 0) hold_cycles = 3000;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 80) begin
          h = well_formed(pool[$urandom_range(0, POOL_FLOWS - 1)],
                          1'($urandom_range(0, 1)), advance_clock());
        end else if (pick < 88) begin
          h = well_formed(random_key(), 1'($urandom_range(0, 1)), advance_clock());
        end else begin
          h = '{flen: 16'($urandom), etype: 16'($urandom), proto: 8'($urandom),
                hw: 4'($urandom), tlen: 16'($urandom), sa: $urandom, da: $urandom,
                sp: 16'($urandom), dp: 16'($urandom), ingress: 1'($urandom),
                ts: {$urandom, $urandom}};
          // Near misses: one bit off the wanted ethertype
          if (pick < 94) h.etype = ETHERTYPE_IPV4 ^ (16'd1 << $urandom_range(0, 15));
        end
        offer(h);
      end
    end

    // Overfill the table with new flows, then hit old flows in the full table
    set_interval(40'd0);
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    for (int n = 0; n < 1060; n++) begin
      k    = random_key();
      k.sa = 32'hA5C0_0000 | n;
      k.da = 32'h5A30_0000 | n;
      offer(well_formed(k, 1'b0, advance_clock()));
    end
    for (int n = 0; n < 12; n++) begin
      offer(well_formed(pool[n], 1'($urandom_range(0, 1)), now_ns + 64'd5 + 64'(n)));
    end
    in_valid <= 1'b0;

    // Drain and give the verdict
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    while (records_pending != 0) @(posedge clk_i);
    if (fail_cnt == 0 && records_pending == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
